[rtl/chp_pkg.sv]
// ----------------------------------------------------------------------------
// chp_pkg
// Types, character codes and byte classifiers shared by the chunk header
// line parser modules.
// ----------------------------------------------------------------------------
package chp_pkg;

    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_BANG   = 8'h21;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_EQ     = 8'h3D;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;
    localparam logic [7:0] CHAR_TILDE  = 8'h7E;
    localparam logic [7:0] CHAR_HIGH   = 8'h80;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_EXT_START,
        PH_NAME,
        PH_VAL_START,
        PH_TOKVAL,
        PH_QUOTED,
        PH_QEND,
        PH_CR
    } phase_t;

    typedef enum logic [3:0] {
        CL_DIGIT  = 4'd0,
        CL_SEMI   = 4'd1,
        CL_NAME   = 4'd2,
        CL_EQ     = 4'd3,
        CL_TOKVAL = 4'd4,
        CL_QVAL   = 4'd5,
        CL_CR     = 4'd6,
        CL_LF     = 4'd7,
        CL_DISC   = 4'd8
    } byte_class_t;

    typedef enum logic [1:0] {
        ST_BUSY,
        ST_OK,
        ST_SYNTAX,
        ST_OVERFLOW
    } status_t;

    // per-byte character flags, produced by the front and queued to the back
    typedef struct packed {
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_tchar;
        logic       is_qdtext;
        logic       is_pair;
        logic       is_semi;
        logic       is_eq;
        logic       is_quote;
        logic       is_bslash;
        logic       is_cr;
        logic       is_lf;
    } char_info_t;

    function automatic logic [4:0] hex_decode(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    function automatic logic tchar_check(logic [7:0] c);
        logic alnum;
        logic sym;
        alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
                (c >= 8'h41 && c <= 8'h5A);
        case (c) inside
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: sym = 1'b1;
            default:                                          sym = 1'b0;
        endcase
        return alnum | sym;
    endfunction

    function automatic logic qdtext_check(logic [7:0] c);
        return (c == CHAR_TAB) || (c == CHAR_SPACE) || (c == CHAR_BANG) ||
               (c >= CHAR_HASH && c <= CHAR_LBRACK) ||
               (c >= CHAR_RBRACK && c <= CHAR_TILDE) || (c >= CHAR_HIGH);
    endfunction

    function automatic logic pair_check(logic [7:0] c);
        return (c == CHAR_TAB) || (c == CHAR_SPACE) ||
               (c >= CHAR_BANG && c <= CHAR_TILDE) || (c >= CHAR_HIGH);
    endfunction

    // extension count as shown on the 4-bit result fields
    function automatic logic [3:0] ext_sat(logic [7:0] v);
        return (v > 8'd15) ? 4'hF : v[3:0];
    endfunction

endpackage

[rtl/chp_front.sv]
// ----------------------------------------------------------------------------
// chp_front
// Classifies each incoming byte into the character flags that the parse
// state machine needs.
// ----------------------------------------------------------------------------
module chp_front (
    input  logic [7:0]          line_byte,
    output chp_pkg::char_info_t info
);
    import chp_pkg::*;

    logic [4:0] hex;

    assign hex = hex_decode(line_byte);

    always_comb
    begin
        info.is_hex    = hex[4];
        info.hex_val   = hex[3:0];
        info.is_tchar  = tchar_check(line_byte);
        info.is_qdtext = qdtext_check(line_byte);
        info.is_pair   = pair_check(line_byte);
        info.is_semi   = (line_byte == CHAR_SEMI);
        info.is_eq     = (line_byte == CHAR_EQ);
        info.is_quote  = (line_byte == CHAR_QUOTE);
        info.is_bslash = (line_byte == CHAR_BSLASH);
        info.is_cr     = (line_byte == CHAR_CR);
        info.is_lf     = (line_byte == CHAR_LF);
    end

endmodule

[rtl/chp_queue.sv]
// ----------------------------------------------------------------------------
// chp_queue
// Two-entry queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module chp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  chp_pkg::char_info_t push_data,
    output logic                push_ready,
    output logic                pop_valid,
    output chp_pkg::char_info_t pop_data,
    input  logic                pop_ready
);
    import chp_pkg::*;

    char_info_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/chp_back.sv]
// ----------------------------------------------------------------------------
// chp_back
// Line grammar state machine: takes one classified byte per cycle from the
// queue while its result register is free or being taken, updates size,
// extension count and phase, and registers the result.
module chp_back #(
    parameter int SIZE_BITS      = 32,
    parameter int EXT_COUNT_BITS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  chp_pkg::char_info_t  q_data,
    output logic                 q_ready,
    output logic                 result_valid,
    input  logic                 result_ready,
    output chp_pkg::byte_class_t byte_class,
    output logic [3:0]           ext_number,
    output logic                 line_done,
    output chp_pkg::status_t     parse_status,
    output logic [31:0]          chunk_size,
    output logic [3:0]           ext_total
);
    import chp_pkg::*;

    phase_t                    phase_reg;
    phase_t                    phase_next;
    logic [SIZE_BITS-1:0]      size_accum_reg;
    logic [SIZE_BITS-1:0]      size_accum_next;
    logic                      digit_seen_reg;
    logic                      digit_seen_next;
    logic                      escape_reg;
    logic                      escape_next;
    logic [EXT_COUNT_BITS-1:0] ext_cnt_reg;
    logic [EXT_COUNT_BITS-1:0] ext_cnt_next;
    logic                      discard_reg;
    logic                      discard_next;

    logic                      out_valid_reg;
    byte_class_t               cls_reg;
    byte_class_t               cls_next;
    logic [3:0]                extn_reg;
    logic [3:0]                extn_next;
    logic                      done_reg;
    logic                      done_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic [31:0]               size_reg;
    logic [31:0]               size_next;
    logic [3:0]                total_reg;
    logic [3:0]                total_next;

    // byte decode against the current phase
    logic                      err;
    logic                      ovf;
    logic                      take_digit;
    logic                      open_ext;
    logic                      ok_line;
    logic                      esc_set;
    logic                      esc_clr;
    logic                      ext_tag;
    phase_t                    phase_tgt;
    byte_class_t               cls_good;

    logic [EXT_COUNT_BITS-1:0] ext_cnt_inc;
    logic [EXT_COUNT_BITS-1:0] ext_cnt_new;
    logic [3:0]                ext_now;
    logic [3:0]                ext_cur;
    logic [63:0]               size_wide;
    logic                      pop;

    assign q_ready = ~out_valid_reg | result_ready;
    assign pop     = q_valid & q_ready;

    assign ext_cnt_inc = (ext_cnt_reg == {EXT_COUNT_BITS{1'b1}}) ? ext_cnt_reg
                       : ext_cnt_reg + EXT_COUNT_BITS'(1);
    assign ext_cnt_new = open_ext ? ext_cnt_inc : ext_cnt_reg;
    assign ext_now     = ext_sat(8'(ext_cnt_new));
    assign ext_cur     = ext_sat(8'(ext_cnt_reg));
    assign size_wide   = 64'(size_accum_reg);

    always_comb
    begin
        err        = 1'b0;
        ovf        = 1'b0;
        take_digit = 1'b0;
        open_ext   = 1'b0;
        ok_line    = 1'b0;
        esc_set    = 1'b0;
        esc_clr    = 1'b0;
        ext_tag    = 1'b0;
        phase_tgt  = phase_reg;
        cls_good   = CL_DISC;
        unique case (phase_reg)
            PH_SIZE:
            begin
                if (q_data.is_hex)
                begin
                    if (size_accum_reg[SIZE_BITS-1 -: 4] != 4'd0)
                    begin
                        err = 1'b1;
                        ovf = 1'b1;
                    end
                    else
                    begin
                        take_digit = 1'b1;
                        cls_good   = CL_DIGIT;
                    end
                end
                else if (q_data.is_semi && digit_seen_reg)
                begin
                    open_ext  = 1'b1;
                    phase_tgt = PH_EXT_START;
                    cls_good  = CL_SEMI;
                    ext_tag   = 1'b1;
                end
                else if (q_data.is_cr && digit_seen_reg)
                begin
                    phase_tgt = PH_CR;
                    cls_good  = CL_CR;
                end
                else
                    err = 1'b1;
            end
            PH_EXT_START:
            begin
                if (q_data.is_tchar)
                begin
                    phase_tgt = PH_NAME;
                    cls_good  = CL_NAME;
                    ext_tag   = 1'b1;
                end
                else
                    err = 1'b1;
            end
            PH_NAME:
            begin
                if (q_data.is_tchar)
                begin
                    cls_good = CL_NAME;
                    ext_tag  = 1'b1;
                end
                else if (q_data.is_eq)
                begin
                    phase_tgt = PH_VAL_START;
                    cls_good  = CL_EQ;
                    ext_tag   = 1'b1;
                end
                else if (q_data.is_semi)
                begin
                    open_ext  = 1'b1;
                    phase_tgt = PH_EXT_START;
                    cls_good  = CL_SEMI;
                    ext_tag   = 1'b1;
                end
                else if (q_data.is_cr)
                begin
                    phase_tgt = PH_CR;
                    cls_good  = CL_CR;
                end
                else
                    err = 1'b1;
            end
            PH_VAL_START:
            begin
                if (q_data.is_tchar)
                begin
                    phase_tgt = PH_TOKVAL;
                    cls_good  = CL_TOKVAL;
                    ext_tag   = 1'b1;
                end
                else if (q_data.is_quote)
                begin
                    phase_tgt = PH_QUOTED;
                    cls_good  = CL_QVAL;
                    ext_tag   = 1'b1;
                end
                else
                    err = 1'b1;
            end
            PH_TOKVAL:
            begin
                if (q_data.is_tchar)
                begin
                    cls_good = CL_TOKVAL;
                    ext_tag  = 1'b1;
                end
                else if (q_data.is_semi)
                begin
                    open_ext  = 1'b1;
                    phase_tgt = PH_EXT_START;
                    cls_good  = CL_SEMI;
                    ext_tag   = 1'b1;
                end
                else if (q_data.is_cr)
                begin
                    phase_tgt = PH_CR;
                    cls_good  = CL_CR;
                end
                else
                    err = 1'b1;
            end
            PH_QUOTED:
            begin
                if (escape_reg)
                begin
                    if (q_data.is_pair)
                        esc_clr = 1'b1;
                    else
                        err = 1'b1;
                end
                else if (q_data.is_bslash)
                    esc_set = 1'b1;
                else if (q_data.is_quote)
                    phase_tgt = PH_QEND;
                else if (!q_data.is_qdtext)
                    err = 1'b1;
                cls_good = CL_QVAL;
                ext_tag  = 1'b1;
            end
            PH_QEND:
            begin
                if (q_data.is_semi)
                begin
                    open_ext  = 1'b1;
                    phase_tgt = PH_EXT_START;
                    cls_good  = CL_SEMI;
                    ext_tag   = 1'b1;
                end
                else if (q_data.is_cr)
                begin
                    phase_tgt = PH_CR;
                    cls_good  = CL_CR;
                end
                else
                    err = 1'b1;
            end
            PH_CR:
            begin
                if (q_data.is_lf)
                begin
                    ok_line  = 1'b1;
                    cls_good = CL_LF;
                end
                else
                    err = 1'b1;
            end
            default:
                err = 1'b1;
        endcase
    end

    // next parser state
    always_comb
    begin
        phase_next      = phase_reg;
        size_accum_next = size_accum_reg;
        digit_seen_next = digit_seen_reg;
        escape_next     = escape_reg;
        ext_cnt_next    = ext_cnt_reg;
        discard_next    = discard_reg;
        if ((discard_reg && q_data.is_lf) || (!discard_reg && err && q_data.is_lf) ||
            (!discard_reg && !err && ok_line))
        begin
            phase_next      = PH_SIZE;
            size_accum_next = '0;
            digit_seen_next = 1'b0;
            escape_next     = 1'b0;
            ext_cnt_next    = '0;
            discard_next    = 1'b0;
        end
        else if (!discard_reg && err)
            discard_next = 1'b1;
        else if (!discard_reg)
        begin
            phase_next   = phase_tgt;
            ext_cnt_next = ext_cnt_new;
            if (take_digit)
            begin
                size_accum_next = (size_accum_reg << 4) | SIZE_BITS'(q_data.hex_val);
                digit_seen_next = 1'b1;
            end
            if (esc_set)
                escape_next = 1'b1;
            else if (esc_clr)
                escape_next = 1'b0;
        end
    end

    // result fields for this byte
    always_comb
    begin
        cls_next    = CL_DISC;
        extn_next   = 4'd0;
        done_next   = 1'b0;
        status_next = ST_BUSY;
        size_next   = 32'd0;
        total_next  = ext_cur;
        if (discard_reg)
        begin
            if (q_data.is_lf)
            begin
                cls_next   = CL_LF;
                total_next = 4'd0;
            end
        end
        else if (err)
        begin
            done_next   = 1'b1;
            status_next = ovf ? ST_OVERFLOW : ST_SYNTAX;
        end
        else
        begin
            cls_next   = cls_good;
            extn_next  = ext_tag ? ext_now : 4'd0;
            total_next = ext_now;
            if (ok_line)
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                size_next   = size_wide[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIZE;
            size_accum_reg <= '0;
            digit_seen_reg <= 1'b0;
            escape_reg     <= 1'b0;
            ext_cnt_reg    <= '0;
            discard_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg      <= phase_next;
                size_accum_reg <= size_accum_next;
                digit_seen_reg <= digit_seen_next;
                escape_reg     <= escape_next;
                ext_cnt_reg    <= ext_cnt_next;
                discard_reg    <= discard_next;
            end
            if (q_ready)
                out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cls_reg    <= cls_next;
            extn_reg   <= extn_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            size_reg   <= size_next;
            total_reg  <= total_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign byte_class   = cls_reg;
    assign ext_number   = extn_reg;
    assign line_done    = done_reg;
    assign parse_status = status_reg;
    assign chunk_size   = size_reg;
    assign ext_total    = total_reg;

endmodule

[rtl/chunk_header_line_parser.sv]
// a byte accepted at the input is written into the queue, then popped by chp_back
//   into its output register, which drives the result outputs
// throughput: one byte per cycle while the output side does not stall, set by the parse step in chp_back
// a two-entry queue decouples input acceptance from output backpressure
// reset (rst_n low, asynchronous): parser returns to the size phase, queue and
//   output register empty
// ----------------------------------------------------------------------------
// chunk_header_line_parser
// Chunk-header line parser: hex size, extension grammar, CR LF check, with
// one classified result per input byte.
// ----------------------------------------------------------------------------
module chunk_header_line_parser #(
    parameter int SIZE_BITS      = 32,
    parameter int EXT_COUNT_BITS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  line_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [3:0]  byte_class,
    output logic [3:0]  ext_number,
    output logic        line_done,
    output logic [1:0]  parse_status,
    output logic [31:0] chunk_size,
    output logic [3:0]  ext_total
);
    import chp_pkg::*;

    char_info_t  front_info;
    char_info_t  q_data;
    logic        q_valid;
    logic        q_ready;
    byte_class_t cls;
    status_t     status;

    chp_front u_front (
        .line_byte (line_byte),
        .info      (front_info)
    );

    chp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (byte_valid),
        .push_data  (front_info),
        .push_ready (byte_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data),
        .pop_ready  (q_ready)
    );

    chp_back #(
        .SIZE_BITS      (SIZE_BITS),
        .EXT_COUNT_BITS (EXT_COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_ready      (q_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .byte_class   (cls),
        .ext_number   (ext_number),
        .line_done    (line_done),
        .parse_status (status),
        .chunk_size   (chunk_size),
        .ext_total    (ext_total)
    );

    assign byte_class   = cls;
    assign parse_status = status;

endmodule

[rtl/chp_checker.sv]
// ----------------------------------------------------------------------------
// chp_checker
// Port-level checks on the chunk header line parser, bound to its top level.
// ----------------------------------------------------------------------------
module chp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [3:0]  byte_class,
    input logic [3:0]  ext_number,
    input logic        line_done,
    input logic [1:0]  parse_status,
    input logic [31:0] chunk_size,
    input logic [3:0]  ext_total
);
    import chp_pkg::*;

    // a stalled result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(byte_class) &&
        $stable(chunk_size) && $stable(parse_status) && $stable(ext_total))
    else $error("result changed while stalled");

    // ok only on the LF that ends the line
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && parse_status == ST_OK |-> line_done && byte_class == CL_LF)
    else $error("ok status without closing LF");

    // line end or error always carries a final status, and errors tag the byte discarded
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && line_done |-> parse_status != ST_BUSY &&
        (parse_status == ST_OK || byte_class == CL_DISC))
    else $error("line_done with inconsistent status");

    // size is only shown with ok, extension tag matches running count
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (parse_status == ST_OK || chunk_size == 32'd0) &&
        (ext_number == 4'd0 || ext_number == ext_total))
    else $error("size or extension number out of place");

endmodule

bind chunk_header_line_parser chp_checker u_chp_checker (.*);
